// ----- hw/rtl/osm_pkg.sv -----
`default_nettype none

package osm_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned REQ_W          = 3;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_DELETE    = 3'd1,
    REQ_KTH_SMALL = 3'd2,
    REQ_KTH_LARGE = 3'd3,
    REQ_PRED      = 3'd4,
    REQ_SUCC      = 3'd5,
    REQ_RANK      = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PROBE,
    S_FETCH,
    S_GOT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/osm_ram.sv -----
`default_nettype none

module osm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/order_statistic_multiset.sv -----
// order_statistic_multiset: a sorted multiset of signed values held in one ram
//
// input stream: s_axis_tuser carries the request code, s_axis_tdata the key and
// the one-based index for the kth queries. output stream: one word per request
// with the answered value, the rank, the count after the request and a status
// code in m_axis_tuser (0 ok, 1 full on insert, 2 missing or out of range).
//
// entries live in ascending order in a ram with a registered read. searches
// are a binary search over the ram, each probe passing through S_SEARCH and
// S_PROBE. kth queries read one entry. insert and delete then move every entry
// above the hit by one place, one entry per cycle through the single ram read
// and write ports. requests are handled one at a time; a word is taken in the
// idle state. a finished result sits in the output register, and the next word
// is accepted while it waits; only a result that finds that register still
// full waits. reset empties the store at once (count cleared), no clearing
// pass is needed, and drops any pending output word.

`default_nettype none

module order_statistic_multiset #(
  parameter int unsigned CAPACITY   = osm_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = osm_pkg::VALUE_BITS_DEF,
  localparam int unsigned IW        = $clog2(CAPACITY + 2),
  localparam int unsigned IN_W      = ((VALUE_BITS + IW + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((VALUE_BITS + 2 * IW + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_value, order_index
  input  wire logic [IN_W-1:0]               s_axis_tdata,
  // req_type
  input  wire logic [osm_pkg::REQ_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // found_value, rank_out, stored_count
  output logic      [OUT_W-1:0]              m_axis_tdata,
  // status
  output logic      [osm_pkg::STATUS_W-1:0]  m_axis_tuser
);

  import osm_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] CapCnt = IW'(CAPACITY);

  state_e                 state_q, state_d;
  req_e                   req_q, req_d;
  logic signed [VALUE_BITS-1:0] key_q, key_d;
  logic [IW-1:0]          count_q, count_d;
  logic [IW-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic                   incl_q, incl_d;
  logic [AW-1:0]          fetch_addr_q, fetch_addr_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_addr_q, pend_addr_d;
  logic [VALUE_BITS-1:0]  found_q, found_d;
  logic [IW-1:0]          rank_q, rank_d;
  status_e                status_q, status_d;

  logic                   m_valid_q, m_valid_d;
  logic [VALUE_BITS-1:0]  out_found_q, out_found_d;
  logic [IW-1:0]          out_rank_q, out_rank_d;
  logic [IW-1:0]          out_count_q, out_count_d;
  status_e                out_status_q, out_status_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0]  ram_wdata, ram_rdata;
  logic signed [VALUE_BITS-1:0] rdata_s;

  logic [IW:0]            mid_sum;
  logic [IW-1:0]          mid;
  logic [IW-1:0]          in_k;
  logic [IW-1:0]          kth_pos;
  req_e                   in_req;
  logic                   probe_below;

  assign rdata_s = $signed(ram_rdata);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign in_k    = s_axis_tdata[VALUE_BITS +: IW];
  assign in_req  = req_e'(s_axis_tuser);
  assign kth_pos = (in_req == REQ_KTH_SMALL) ? (in_k - 1'b1) : (count_q - in_k);
  assign probe_below = incl_q ? (rdata_s <= key_q) : (rdata_s < key_q);

  osm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    incl_q       <= incl_d;
    fetch_addr_q <= fetch_addr_d;
    rd_idx_q     <= rd_idx_d;
    pend_q       <= pend_d;
    pend_addr_q  <= pend_addr_d;
    found_q      <= found_d;
    rank_q       <= rank_d;
    status_q     <= status_d;
    out_found_q  <= out_found_d;
    out_rank_q   <= out_rank_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    incl_d       = incl_q;
    fetch_addr_d = fetch_addr_q;
    rd_idx_d     = rd_idx_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    found_d      = found_q;
    rank_d       = rank_q;
    status_d     = status_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    out_found_d  = out_found_q;
    out_rank_d   = out_rank_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    s_axis_tready = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = mid[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d    = in_req;
          key_d    = $signed(s_axis_tdata[VALUE_BITS-1:0]);
          found_d  = '0;
          rank_d   = '0;
          status_d = ST_OK;
          lo_d     = '0;
          hi_d     = count_q;
          unique case (in_req) inside
            REQ_INSERT: begin
              if (count_q >= CapCnt) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                incl_d  = 1'b1;
                state_d = S_SEARCH;
              end
            end
            REQ_DELETE, REQ_PRED, REQ_RANK: begin
              incl_d  = 1'b0;
              state_d = S_SEARCH;
            end
            REQ_SUCC: begin
              incl_d  = 1'b1;
              state_d = S_SEARCH;
            end
            REQ_KTH_SMALL, REQ_KTH_LARGE: begin
              if (in_k == '0 || in_k > count_q) begin
                status_d = ST_MISS;
                state_d  = S_DONE;
              end else begin
                fetch_addr_d = kth_pos[AW-1:0];
                state_d      = S_FETCH;
              end
            end
            default: begin
              status_d = ST_MISS;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (lo_q < hi_q) begin
          // ram_raddr already points at mid
          state_d = S_PROBE;
        end else begin
          unique case (req_q) inside
            REQ_INSERT: begin
              rd_idx_d = count_q;
              pend_d   = 1'b0;
              state_d  = S_SHIFT_UP;
            end
            REQ_DELETE, REQ_SUCC: begin
              if (lo_q >= count_q) begin
                status_d = ST_MISS;
                state_d  = S_DONE;
              end else begin
                fetch_addr_d = lo_q[AW-1:0];
                state_d      = S_FETCH;
              end
            end
            REQ_PRED: begin
              if (lo_q == '0) begin
                status_d = ST_MISS;
                state_d  = S_DONE;
              end else begin
                fetch_addr_d = AW'(lo_q - 1'b1);
                state_d      = S_FETCH;
              end
            end
            REQ_RANK: begin
              rank_d  = lo_q + 1'b1;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_PROBE: begin
        if (probe_below) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = S_SEARCH;
      end

      S_FETCH: begin
        ram_raddr = fetch_addr_q;
        state_d   = S_GOT;
      end

      S_GOT: begin
        if (req_q == REQ_DELETE) begin
          if (rdata_s == key_q) begin
            rd_idx_d = lo_q + 1'b1;
            pend_d   = 1'b0;
            state_d  = S_SHIFT_DN;
          end else begin
            status_d = ST_MISS;
            state_d  = S_DONE;
          end
        end else begin
          found_d = ram_rdata;
          state_d = S_DONE;
        end
      end

      // move entries up one place, top first: read below while writing above
      S_SHIFT_UP: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q + 1'b1;
          ram_wdata = ram_rdata;
        end
        if (rd_idx_q > lo_q) begin
          ram_raddr   = AW'(rd_idx_q - 1'b1);
          pend_addr_d = AW'(rd_idx_q - 1'b1);
          rd_idx_d    = rd_idx_q - 1'b1;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = lo_q[AW-1:0];
            ram_wdata = key_q;
            count_d   = count_q + 1'b1;
            state_d   = S_DONE;
          end
        end
      end

      // move entries down one place over the deleted slot, bottom first
      S_SHIFT_DN: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (rd_idx_q < count_q) begin
          ram_raddr   = rd_idx_q[AW-1:0];
          pend_addr_d = rd_idx_q[AW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d    = 1'b1;
          out_found_d  = found_q;
          out_rank_d   = rank_q;
          out_count_d  = count_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[VALUE_BITS-1:0]           = out_found_q;
    m_axis_tdata[VALUE_BITS +: IW]         = out_rank_q;
    m_axis_tdata[VALUE_BITS + IW +: IW]    = out_count_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/osm_checker.sv -----
`default_nettype none

module osm_checker #(
  parameter int unsigned CAPACITY   = osm_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = osm_pkg::VALUE_BITS_DEF,
  localparam int unsigned IW        = $clog2(CAPACITY + 2),
  localparam int unsigned OUT_W     = ((VALUE_BITS + 2 * IW + 7) / 8) * 8
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [OUT_W-1:0]             m_axis_tdata,
  input wire logic [osm_pkg::STATUS_W-1:0] m_axis_tuser
);

  import osm_pkg::*;

  logic [VALUE_BITS-1:0] found;
  logic [IW-1:0]         rank;
  logic [IW-1:0]         count;

  assign found = m_axis_tdata[VALUE_BITS-1:0];
  assign rank  = m_axis_tdata[VALUE_BITS +: IW];
  assign count = m_axis_tdata[VALUE_BITS + IW +: IW];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count <= IW'(CAPACITY))
    else $error("stored count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_FULL |-> count == IW'(CAPACITY))
    else $error("full status with room left");

  a_rank_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rank != '0 |-> m_axis_tuser == ST_OK && found == '0)
    else $error("rank word carries a value or an error");

endmodule

bind order_statistic_multiset osm_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS)
) u_osm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
